@@ hdl/plen_pkg.sv @@
package plen_pkg;

	// Default list capacity and the fixed field widths of the two channels.
	localparam int CAPACITY_DEF = 256;
	localparam int ACT_W        = 2;
	localparam int POS_W        = 9;
	localparam int DATA_W       = 32;
	localparam int STAT_W       = 3;

	// Cell index width; it covers a chain of up to 4096 cells.
	localparam int IDX_MAX_W    = 12;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_READ   = 2'd2,
		ACT_FIND   = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_EMPTY    = 3'd1,
		STAT_BADPOS   = 3'd2,
		STAT_NOTFOUND = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_ROTATE
	} cell_op_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		cell_op_t               op;
		logic [IDX_MAX_W-1:0]   target;
		logic [IDX_MAX_W-1:0]   last;
	} cell_ctl_t;

	typedef enum logic {
		CS_IDLE,
		CS_SCAN
	} ctl_state_t;

endpackage

@@ hdl/plen_cmd_if.sv @@
interface plen_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [plen_pkg::ACT_W-1:0]         action;
	logic [plen_pkg::POS_W-1:0]         position;
	logic signed [plen_pkg::DATA_W-1:0] value;

	modport source (output valid, output action, output position, output value, input ready);
	modport sink   (input valid, input action, input position, input value, output ready);
endinterface

@@ hdl/plen_rsp_if.sv @@
interface plen_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [plen_pkg::DATA_W-1:0] read_value;
	logic [plen_pkg::POS_W-1:0]         found_position;
	logic [plen_pkg::POS_W-1:0]         list_size;
	logic [plen_pkg::STAT_W-1:0]        status;

	modport source (output valid, output read_value, output found_position, output list_size,
		output status, input ready);
	modport sink   (input valid, input read_value, input found_position, input list_size,
		input status, output ready);
endinterface

@@ hdl/plen_cell.sv @@
module plen_cell #(
	parameter int IDX = 0
) (
	input  logic                               clk,
	input  plen_pkg::cell_ctl_t                ctl,
	input  logic signed [plen_pkg::DATA_W-1:0] load_value,
	input  logic signed [plen_pkg::DATA_W-1:0] left_value,
	input  logic signed [plen_pkg::DATA_W-1:0] right_value,
	input  logic signed [plen_pkg::DATA_W-1:0] head_value,
	output logic signed [plen_pkg::DATA_W-1:0] entry
);
	import plen_pkg::*;

	localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

	logic signed [DATA_W-1:0] entry_q;
	logic signed [DATA_W-1:0] entry_d;

	// Each cell picks its next value from itself, a neighbor, the head or the new value.
	always_comb begin
		entry_d = entry_q;
		case (ctl.op)
			CELL_INSERT: begin
				if (MY_IDX == ctl.target) begin
					entry_d = load_value;
				end else if (MY_IDX > ctl.target) begin
					entry_d = left_value;
				end
			end
			CELL_REMOVE: begin
				if (MY_IDX >= ctl.target) begin
					entry_d = right_value;
				end
			end
			CELL_ROTATE: begin
				if (MY_IDX == ctl.last) begin
					entry_d = head_value;
				end else if (MY_IDX < ctl.last) begin
					entry_d = right_value;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

@@ hdl/positional_list_engine.sv @@
// Channel | Dir | Beat payload                                        | Handshake
// cmd     | in  | action, position, value                             | valid/ready
// rsp     | out | read_value, found_position, list_size, status       | valid/ready
//
// Insert, remove and every rejected action take one cycle: the chain shifts in the
// accepting cycle and the result beat is presented in the next one.
// Read and find rotate the list once through cell 0, so the block is busy for
// list_size cycles after the accepting cycle before the result beat appears.
// Reset clears the entry count and the control state; the cell contents are not reset.
// A stalled result beat holds, and a new command beat is taken in the same cycle that
// the previous result beat is taken.
module positional_list_engine #(
	parameter int CAPACITY = plen_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	plen_cmd_if.sink    cmd,
	plen_rsp_if.source  rsp
);
	import plen_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// The list lives in a row of cells; cell 0 holds position 1.
	logic signed [DATA_W-1:0] entry_w [CAPACITY];
	cell_ctl_t                cell_ctl;

	// Control and count state.
	ctl_state_t               state_q;
	ctl_state_t               state_d;
	logic [CNT_W-1:0]         count_q;

	// Parameters of the action under scan.
	action_t                  act_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]         step_q;
	logic                     found_q;
	logic signed [DATA_W-1:0] scan_rd_q;
	logic [POS_W-1:0]         scan_fp_q;

	// Result register.
	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] rsp_rd_q;
	logic [POS_W-1:0]         rsp_fp_q;
	logic [POS_W-1:0]         rsp_size_q;
	status_t                  rsp_stat_q;

	// Decode of the incoming beat.
	action_t                  cmd_act;
	logic [CMP_W-1:0]         pos_x;
	logic [CMP_W-1:0]         cnt_x;
	logic                     list_full;
	logic                     list_empty;
	logic                     ins_ok;
	logic                     pos_ok;
	logic                     need_scan;
	logic                     accept;
	status_t                  imm_stat;
	logic [CNT_W-1:0]         imm_count;

	// Scan datapath.
	logic signed [DATA_W-1:0] head;
	logic                     scan_last;
	logic                     read_hit;
	logic                     find_hit;
	logic [POS_W-1:0]         step_pos;
	logic signed [DATA_W-1:0] fin_rd;
	logic [POS_W-1:0]         fin_fp;
	status_t                  fin_stat;

	// ------------------------------------------------------------------
	// Chain of cells. Each cell sees its two neighbors, the head cell and the
	// new value; the broadcast command tells it which of them to take.
	// ------------------------------------------------------------------
	assign head = entry_w[0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_v;
		logic signed [DATA_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = cmd.value;
		end else begin : g_mid_l
			assign left_v = entry_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign right_v = entry_w[i];
		end else begin : g_mid_r
			assign right_v = entry_w[i+1];
		end

		plen_cell #(
			.IDX (i)
		) u_cell (
			.clk         (clk),
			.ctl         (cell_ctl),
			.load_value  (cmd.value),
			.left_value  (left_v),
			.right_value (right_v),
			.head_value  (head),
			.entry       (entry_w[i])
		);
	end

	// ------------------------------------------------------------------
	// Decode the command beat against the current count. Positions are
	// one-based, so a position is valid from 1 up to the count (or the count
	// plus one for insert). A full list is checked before the position.
	// ------------------------------------------------------------------
	always_comb begin
		cmd_act    = action_t'(cmd.action);
		pos_x      = CMP_W'(cmd.position);
		cnt_x      = CMP_W'(count_q);
		list_full  = (count_q == CNT_W'(CAPACITY));
		list_empty = (count_q == '0);
		ins_ok     = !list_full && (cmd.position != '0) && (pos_x <= cnt_x + CMP_W'(1));
		pos_ok     = !list_empty && (cmd.position != '0) && (pos_x <= cnt_x);
		need_scan  = ((cmd_act == ACT_READ) && pos_ok) ||
			((cmd_act == ACT_FIND) && !list_empty);
		imm_count  = count_q;
		imm_stat   = STAT_OK;
		unique case (cmd_act)
			ACT_INSERT: begin
				if (list_full) begin
					imm_stat = STAT_FULL;
				end else if (!ins_ok) begin
					imm_stat = STAT_BADPOS;
				end else begin
					imm_count = count_q + CNT_W'(1);
				end
			end
			ACT_REMOVE: begin
				if (list_empty) begin
					imm_stat = STAT_EMPTY;
				end else if (!pos_ok) begin
					imm_stat = STAT_BADPOS;
				end else begin
					imm_count = count_q - CNT_W'(1);
				end
			end
			ACT_READ: begin
				// Only rejected reads finish here; good ones go to the scan.
				imm_stat = list_empty ? STAT_EMPTY : STAT_BADPOS;
			end
			ACT_FIND: begin
				imm_stat = STAT_EMPTY;
			end
			default: begin
				imm_stat = STAT_OK;
			end
		endcase
	end

	assign accept = cmd.valid && cmd.ready;

	// ------------------------------------------------------------------
	// Scan: the list rotates by one entry a cycle inside a ring that is as
	// long as the list, so after count steps every entry is back in place.
	// At step k cell 0 holds the entry of position k+1.
	// ------------------------------------------------------------------
	always_comb begin
		scan_last = (step_q == IDX_W'(count_q - CNT_W'(1)));
		step_pos  = POS_W'(CMP_W'(step_q) + CMP_W'(1));
		read_hit  = (act_q == ACT_READ) &&
			((CMP_W'(step_q) + CMP_W'(1)) == CMP_W'(pos_q));
		find_hit  = (act_q == ACT_FIND) && !found_q && (head == val_q);
		fin_rd    = read_hit ? head : scan_rd_q;
		fin_fp    = find_hit ? step_pos : scan_fp_q;
		if ((act_q == ACT_FIND) && !found_q && !find_hit) begin
			fin_stat = STAT_NOTFOUND;
		end else begin
			fin_stat = STAT_OK;
		end
	end

	// ------------------------------------------------------------------
	// Controller: next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (accept && need_scan) begin
					state_d = CS_SCAN;
				end
			end
			CS_SCAN: begin
				if (scan_last) begin
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Controller: outputs. A command beat is taken only when idle and the
	// result register is free or being emptied in this cycle.
	// ------------------------------------------------------------------
	always_comb begin
		cmd.ready       = 1'b0;
		cell_ctl.op     = CELL_HOLD;
		cell_ctl.target = IDX_MAX_W'(cmd.position) - IDX_MAX_W'(1);
		cell_ctl.last   = IDX_MAX_W'(count_q - CNT_W'(1));
		unique case (state_q)
			CS_IDLE: begin
				cmd.ready = !rsp_valid_q || rsp.ready;
				if (cmd.valid && cmd.ready) begin
					if ((cmd_act == ACT_INSERT) && ins_ok) begin
						cell_ctl.op = CELL_INSERT;
					end else if ((cmd_act == ACT_REMOVE) && pos_ok) begin
						cell_ctl.op = CELL_REMOVE;
					end
				end
			end
			CS_SCAN: begin
				cell_ctl.op = CELL_ROTATE;
			end
			default: begin
				cmd.ready = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= imm_count;
			end
			if ((accept && !need_scan) || ((state_q == CS_SCAN) && scan_last)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Scan and result payload registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= cmd_act;
			pos_q     <= cmd.position;
			val_q     <= cmd.value;
			step_q    <= '0;
			found_q   <= 1'b0;
			scan_rd_q <= '0;
			scan_fp_q <= '0;
		end else if (state_q == CS_SCAN) begin
			step_q    <= step_q + IDX_W'(1);
			found_q   <= found_q || find_hit;
			scan_rd_q <= fin_rd;
			scan_fp_q <= fin_fp;
		end

		if (accept && !need_scan) begin
			rsp_rd_q   <= '0;
			rsp_fp_q   <= '0;
			rsp_size_q <= POS_W'(imm_count);
			rsp_stat_q <= imm_stat;
		end else if ((state_q == CS_SCAN) && scan_last) begin
			rsp_rd_q   <= fin_rd;
			rsp_fp_q   <= fin_fp;
			rsp_size_q <= POS_W'(count_q);
			rsp_stat_q <= fin_stat;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_value     = rsp_rd_q;
	assign rsp.found_position = rsp_fp_q;
	assign rsp.list_size      = rsp_size_q;
	assign rsp.status         = rsp_stat_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// The count never exceeds the number of cells.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// A rotation must not change the count, or the ring would lose entries.
	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_SCAN) |=> (count_q == $past(count_q)))
		else $error("count changed during scan");

	// While scanning, the result register has been emptied and stays empty.
	a_scan_rsp_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_SCAN) && $past(state_q == CS_SCAN) |-> !rsp_valid_q)
		else $error("result pending during scan");

	// An accepted good insert grows the list by exactly one.
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd_act == ACT_INSERT) && ins_ok |=>
		(count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the list");

endmodule
